FILE: design/urta_pkg.sv
// ----------------------------------------------------------------------------
// urta_pkg: shared constants and helpers for the radix-to-ASCII converter
// Radix limits, default sizes and the digit-to-character mapping.
// ----------------------------------------------------------------------------
package urta_pkg;

	localparam int VALUE_BITS_DEF = 32;
	localparam int MAX_DIGITS_DEF = 32;

	localparam int RADIX_W  = 5;
	localparam int DIGIT_W  = 4;
	localparam int CHAR_W   = 7;
	localparam int IN_W     = 32;

	localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;
	localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;  // '0'
	localparam logic [CHAR_W-1:0] CHAR_NINE  = 7'h39;  // '9'
	localparam logic [CHAR_W-1:0] CHAR_LOW_A = 7'h61;  // 'a'
	localparam logic [CHAR_W-1:0] CHAR_LOW_F = 7'h66;  // 'f'
	localparam logic [CHAR_W-1:0] CHAR_NONE  = 7'h00;

	// digit value 0..15 -> '0'..'9', 'a'..'f'
	function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] d_ext;
		d_ext = {{(CHAR_W-DIGIT_W){1'b0}}, d};
		if (d < 4'd10) begin
			return CHAR_ZERO + d_ext;
		end else begin
			return CHAR_LOW_A - 7'd10 + d_ext;
		end
	endfunction

endpackage

FILE: design/unsigned_radix_to_ascii.sv
// ----------------------------------------------------------------------------
// unsigned_radix_to_ascii: unsigned integer to lower-case ASCII digits
// Bit-serial restoring division by the radix forms the digits least
// significant first on a digit stack; they are popped most significant first.
// ----------------------------------------------------------------------------
// Operation: one quotient bit per cycle through the shared divider forms
//   each digit, then the digits transfer out one per cycle while the output
//   is not stalled; an invalid radix gives a single error result instead.
// Throughput: one item at a time; the input stalls until the last result is loaded.
// Reset: arst_n clears the control state and the output valid, and sets radix
//   to 10; the digit stack is not reset.
module unsigned_radix_to_ascii
	import urta_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEF,
	parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [RADIX_W-1:0]  cfg_wr_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [IN_W-1:0]     value_in,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [CHAR_W-1:0]   digit_char,
	output logic                last_digit,
	output logic                base_error
);

	localparam int BW = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
	localparam int CW = $clog2(MAX_DIGITS + 1);
	localparam logic [BW-1:0] BIT_LAST = BW'(VALUE_BITS - 1);
	localparam logic [CW-1:0] DIG_LAST = CW'(MAX_DIGITS - 1);
	localparam logic [CW-1:0] DIG_ONE  = CW'(1);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_DIV  = 4'b0010,
		ST_EMIT = 4'b0100,
		ST_ERR  = 4'b1000
	} state_t;

	state_t                  state_q;
	logic [RADIX_W-1:0]      radix_q;
	logic [BW-1:0]           bit_cnt_q;
	logic [CW-1:0]           dig_cnt_q;
	logic [VALUE_BITS-1:0]   val_q;
	logic [DIGIT_W-1:0]      rem_q;
	logic [DIGIT_W-1:0]      stack_q [MAX_DIGITS];
	logic                    out_valid_q;
	logic [CHAR_W-1:0]       digit_char_q;
	logic                    last_digit_q;
	logic                    base_error_q;

	logic                    radix_ok;
	logic [RADIX_W-1:0]      trial;
	logic                    q_bit;
	logic [RADIX_W-1:0]      rem_nx;
	logic [VALUE_BITS-1:0]   val_nx;
	logic                    accept;
	logic                    div_end;
	logic                    out_free;
	logic                    push;
	logic                    pop;
	logic                    load_err;

	assign radix_ok = (radix_q >= RADIX_MIN) && (radix_q <= RADIX_MAX);

	// one restoring-division step: bring down the next dividend bit
	assign trial  = {rem_q, val_q[VALUE_BITS-1]};
	assign q_bit  = (trial >= radix_q);
	assign rem_nx = q_bit ? (trial - radix_q) : trial;
	assign val_nx = {val_q[VALUE_BITS-2:0], q_bit};

	assign accept   = (state_q == ST_IDLE) && in_valid;
	assign div_end  = (state_q == ST_DIV) && (bit_cnt_q == '0);
	assign out_free = !out_valid_q || !out_stall;
	assign push     = div_end;
	assign pop      = (state_q == ST_EMIT) && out_free;
	assign load_err = (state_q == ST_ERR) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
		end else if (cfg_wr_en) begin
			radix_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			bit_cnt_q <= '0;
			dig_cnt_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						bit_cnt_q <= BIT_LAST;
						dig_cnt_q <= '0;
						state_q   <= radix_ok ? ST_DIV : ST_ERR;
					end
				end
				ST_DIV: begin
					if (bit_cnt_q == '0) begin
						bit_cnt_q <= BIT_LAST;
						dig_cnt_q <= dig_cnt_q + DIG_ONE;
						// stop once the quotient runs out or the stack is full
						if ((val_nx == '0) || (dig_cnt_q == DIG_LAST)) begin
							state_q <= ST_EMIT;
						end
					end else begin
						bit_cnt_q <= bit_cnt_q - BW'(1);
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						dig_cnt_q <= dig_cnt_q - DIG_ONE;
						if (dig_cnt_q == DIG_ONE) begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_ERR: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// dividend/quotient shift register and partial remainder
	always_ff @(posedge clk) begin
		if (accept) begin
			val_q <= VALUE_BITS'(value_in);
			rem_q <= '0;
		end else if (state_q == ST_DIV) begin
			val_q <= val_nx;
			rem_q <= div_end ? '0 : rem_nx[DIGIT_W-1:0];
		end
	end

	// digit stack: push at the bottom while dividing, pop from the bottom
	always_ff @(posedge clk) begin
		if (push) begin
			stack_q[0] <= rem_nx[DIGIT_W-1:0];
			for (int i = 1; i < MAX_DIGITS; i++) begin
				stack_q[i] <= stack_q[i-1];
			end
		end else if (pop) begin
			for (int i = 0; i < MAX_DIGITS - 1; i++) begin
				stack_q[i] <= stack_q[i+1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop || load_err) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			digit_char_q <= glyph(stack_q[0]);
			last_digit_q <= (dig_cnt_q == DIG_ONE);
			base_error_q <= 1'b0;
		end else if (load_err) begin
			digit_char_q <= CHAR_NONE;
			last_digit_q <= 1'b1;
			base_error_q <= 1'b1;
		end
	end

	assign in_stall   = (state_q != ST_IDLE);
	assign out_valid  = out_valid_q;
	assign digit_char = digit_char_q;
	assign last_digit = last_digit_q;
	assign base_error = base_error_q;

endmodule

FILE: design/urta_checker.sv
// ----------------------------------------------------------------------------
// urta_checker: port-level checks for the radix-to-ASCII converter
// Watches the handshakes and result fields and is bound to the top level.
// ----------------------------------------------------------------------------
module urta_checker
	import urta_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  logic [IN_W-1:0]     value_in,
	input  logic                out_valid,
	input  logic                out_stall,
	input  logic [CHAR_W-1:0]   digit_char,
	input  logic                last_digit,
	input  logic                base_error
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(digit_char)
			&& $stable(last_digit) && $stable(base_error))
		else $error("result changed while stalled");

	// hold a stalled input value
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> $stable(value_in))
		else $error("input value changed while stalled");

	// an error result carries no digit and closes the item
	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && base_error |-> (digit_char == CHAR_NONE) && last_digit)
		else $error("malformed error result");

	// a digit result is always a lower-case hex character
	a_digit_char: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !base_error |->
			((digit_char >= CHAR_ZERO) && (digit_char <= CHAR_NINE))
			|| ((digit_char >= CHAR_LOW_A) && (digit_char <= CHAR_LOW_F)))
		else $error("digit result is not a valid character");

	// one item at a time: the input stalls right after a transfer
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after transfer");

endmodule

bind unsigned_radix_to_ascii urta_checker u_urta_checker (.*);
